@@ rtl/core/tmps_pkg.sv @@
// Shared types and constants for the triangle minimum path sum block.
package tmps_pkg;

    // Width of one best-path sum and its saturation limits
    localparam int SUM_W = 24;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MID_ROW  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // One triangle entry
    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } in_beat_t;

    // One result
    typedef struct packed {
        logic signed [SUM_W-1:0] path_sum;
        logic [1:0]              status;
    } out_beat_t;

endpackage

@@ rtl/core/triangle_min_path_sum.sv @@
// Top level: streaming triangle minimum path sum over a one-row memory buffer.
//
//   channel   ports                      dir   beat contents
//   s_        s_valid s_ready s_data     in    value (16b signed), last
//   m_        m_valid m_ready m_data     out   path_sum (24b signed), status (2b)
//
// One entry per cycle, back to back. An entry reads its upper neighbor from the row
// buffer when accepted and writes its new sum when its stage advances; a read of the
// entry written in that same cycle takes the forwarded sum. A last entry's result
// passes the stage register into the output register. Reset is synchronous, active
// low, and needs no clearing pass. A stalled result holds the whole pipe, s_ready low.
module triangle_min_path_sum #(
    parameter int MAX_ROWS   = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tmps_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tmps_pkg::out_beat_t  m_data
);

    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RI_W = $clog2(MAX_ROWS + 1);
    localparam int SW   = tmps_pkg::SUM_W;
    // Entries wider than the field are taken unsigned from its 16 bits
    localparam bit ZERO_EXT = (VALUE_BITS > 16);
    localparam int SIGN_BIT = (VALUE_BITS > 16) ? 15 : VALUE_BITS - 1;

    // Work carried from the accept cycle to the update cycle
    typedef struct packed {
        logic               valid;
        logic signed [15:0] value;
        logic               last;
        logic               first_row;
        logic               up_ok;
        logic               diag_ok;
        logic               row_end;
        logic               ovf;
        logic               fwd;
        logic [AW-1:0]      addr;
    } stage_t;

    logic                 adv;
    logic                 accept;
    logic [RI_W-1:0]      row_index_reg, row_index_next;
    logic [AW-1:0]        col_index_reg, col_index_next;
    logic                 ovf_reg, ovf_next;
    logic                 row_full;
    logic [RI_W-1:0]      col_ext;
    stage_t               st1_reg, st1_next;
    logic signed [SW-1:0] left_carry_reg, left_carry_next;
    logic signed [SW-1:0] row_min_reg, row_min_next;
    logic signed [SW-1:0] last_sum_reg;
    logic signed [SW-1:0] rd_data;
    logic signed [SW-1:0] up_val;
    logic signed [SW-1:0] best;
    logic signed [25:0]   v_ext;
    logic signed [25:0]   sum_wide;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] min_now;
    logic                 st1_go;
    logic                 wr_en;
    logic                 m_valid_reg, m_valid_next;
    tmps_pkg::out_beat_t  m_data_reg, m_data_next;

    // Advance the pipe whenever the output register is free or being drained
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign st1_go  = adv && st1_reg.valid;
    assign wr_en   = st1_go && !st1_reg.ovf;

    // Position bookkeeping at accept
    assign row_full = (row_index_reg == RI_W'(MAX_ROWS));
    assign col_ext  = RI_W'(col_index_reg);

    always_comb begin
        row_index_next = row_index_reg;
        col_index_next = col_index_reg;
        ovf_next       = ovf_reg;
        st1_next       = st1_reg;
        if (adv) begin
            st1_next.valid = 1'b0;
        end
        if (accept) begin
            st1_next.valid     = 1'b1;
            st1_next.value     = s_data.value;
            st1_next.last      = s_data.last;
            st1_next.first_row = (row_index_reg == '0);
            st1_next.up_ok     = (col_ext < row_index_reg);
            st1_next.diag_ok   = (col_index_reg != '0);
            st1_next.row_end   = (col_ext >= row_index_reg);
            st1_next.ovf       = ovf_reg || row_full;
            st1_next.addr      = col_index_reg;
            st1_next.fwd       = wr_en && (st1_reg.addr == col_index_reg);
            if (row_full) begin
                ovf_next = 1'b1;
            end else if (col_ext >= row_index_reg) begin
                row_index_next = row_index_reg + RI_W'(1);
                col_index_next = '0;
            end else begin
                col_index_next = col_index_reg + AW'(1);
            end
            if (s_data.last) begin
                row_index_next = '0;
                col_index_next = '0;
                ovf_next       = 1'b0;
            end
        end
    end

    // Advance position and stage; position, overflow flag and the stage valid bit are reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_index_reg <= '0;
            col_index_reg <= '0;
            ovf_reg       <= 1'b0;
            st1_reg.valid <= 1'b0;
        end else begin
            row_index_reg <= row_index_next;
            col_index_reg <= col_index_next;
            ovf_reg       <= ovf_next;
            st1_reg       <= st1_next;
        end
    end

    tmps_row_ram #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (st1_reg.addr),
        .wr_data (sum),
        .rd_en   (accept),
        .rd_addr (col_index_reg),
        .rd_data (rd_data)
    );

    // Extend the entry to 26 bits, two above the sum width
    always_comb begin
        v_ext = '0;
        for (int i = 0; i < 16; i++) begin
            v_ext[i] = (ZERO_EXT || i <= SIGN_BIT) ? st1_reg.value[i]
                                                  : st1_reg.value[SIGN_BIT];
        end
        for (int i = 16; i < 26; i++) begin
            v_ext[i] = ZERO_EXT ? 1'b0 : st1_reg.value[SIGN_BIT];
        end
    end

    // Add the smaller of the available upper neighbors (none on the top row), then saturate
    assign up_val = st1_reg.fwd ? last_sum_reg : rd_data;

    always_comb begin
        if (st1_reg.up_ok && st1_reg.diag_ok) begin
            best = (up_val < left_carry_reg) ? up_val : left_carry_reg;
        end else if (st1_reg.up_ok) begin
            best = up_val;
        end else begin
            best = left_carry_reg;
        end
        if (st1_reg.first_row) begin
            sum_wide = v_ext;
        end else begin
            sum_wide = v_ext + {{2{best[SW-1]}}, best};
        end
        if (sum_wide > 26'(tmps_pkg::SUM_MAX)) begin
            sum = tmps_pkg::SUM_MAX;
        end else if (sum_wide < 26'(tmps_pkg::SUM_MIN)) begin
            sum = tmps_pkg::SUM_MIN;
        end else begin
            sum = sum_wide[SW-1:0];
        end
        min_now = (sum < row_min_reg) ? sum : row_min_reg;
    end

    // Update carry, row minimum and the result
    always_comb begin
        left_carry_next = left_carry_reg;
        row_min_next    = row_min_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        if (st1_go) begin
            if (!st1_reg.ovf) begin
                row_min_next = min_now;
                if (!st1_reg.first_row && st1_reg.up_ok) begin
                    left_carry_next = up_val;
                end
                if (st1_reg.row_end) begin
                    left_carry_next = '0;
                    row_min_next    = tmps_pkg::SUM_MAX;
                end
            end
            if (st1_reg.last) begin
                left_carry_next = '0;
                row_min_next    = tmps_pkg::SUM_MAX;
                m_valid_next    = 1'b1;
                m_data_next.path_sum = '0;
                if (st1_reg.ovf) begin
                    m_data_next.status = tmps_pkg::STATUS_OVERFLOW;
                end else if (!st1_reg.row_end) begin
                    m_data_next.status = tmps_pkg::STATUS_MID_ROW;
                end else begin
                    m_data_next.status   = tmps_pkg::STATUS_OK;
                    m_data_next.path_sum = min_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_carry_reg <= '0;
            row_min_reg    <= tmps_pkg::SUM_MAX;
            m_valid_reg    <= 1'b0;
        end else begin
            left_carry_reg <= left_carry_next;
            row_min_reg    <= row_min_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the last written sum for forwarding, and the result payload
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            last_sum_reg <= sum;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result that is not ok carries a zero sum
    a_err_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != tmps_pkg::STATUS_OK) |-> (m_data.path_sum == '0))
        else $error("error result with nonzero path sum");

    // The column never passes the row end while the triangle fits
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !row_full |-> (col_ext <= row_index_reg))
        else $error("column index beyond row end");

    // A last entry returns the position to the top of the triangle
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last) |=>
            (row_index_reg == '0 && col_index_reg == '0 && !ovf_reg))
        else $error("position not cleared after last entry");

    // Below the top row, forwarding only feeds the first column of row one
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_reg.valid && st1_reg.fwd && !st1_reg.first_row) |->
            (st1_reg.addr == '0 && st1_reg.up_ok))
        else $error("unexpected forward");

endmodule

@@ rtl/core/tmps_row_ram.sv @@
// Row buffer of best path sums: one write port, one registered read port.
module tmps_row_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [tmps_pkg::SUM_W-1:0]   wr_data,
    input  logic                                rd_en,
    input  logic [AW-1:0]                       rd_addr,
    output logic signed [tmps_pkg::SUM_W-1:0]   rd_data
);

    logic signed [tmps_pkg::SUM_W-1:0] mem [DEPTH];
    logic signed [tmps_pkg::SUM_W-1:0] rd_data_reg;

    // Write the updated sum
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data; a read during a write to the same entry returns old data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
